[rtl/core/pwss_pkg.sv]
// Package for the priority work-stealing scheduler.
// Opcodes, status codes and the config register indexes; no dependencies.
package pwss_pkg;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;
  localparam int PRIO_BITS   = 8;

  localparam logic [OP_BITS-1:0] OP_SUBMIT   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TRY      = 2'd1;
  localparam logic [OP_BITS-1:0] OP_COMPLETE = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_STOPPED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NO_IDLE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NO_TASK = 3'd4;

  localparam logic CFG_WORKER_COUNT = 1'b0;
  localparam logic CFG_POOL_STOPPED = 1'b1;

endpackage

[rtl/core/pwss_queue_mem.sv]
// Queue storage for all workers: one memory, one write and one registered read per cycle.
// Depends on nothing; sized by the top level parameters.
module pwss_queue_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/priority_work_stealing_scheduler.sv]
// Top level of the priority work-stealing scheduler: handshakes, sequencer, worker state.
// Depends on pwss_pkg and pwss_queue_mem.
//
// One item is handled at a time. Status-only answers, and a start on an idle worker whose
// queue is empty, pass through S_DECIDE and S_OUT only. A sorted insert walks the target
// queue from the back, one entry at a time through the single read port of the queue
// memory, shifting as it goes. A pop shifts the remaining entries forward one per cycle.
// A completion pops the worker's own queue if it holds entries; else it scans the other
// queue lengths for a steal, one worker a cycle, up to the worker count in use.
// The result sits in an output register; the next item is taken once it is gone.
module priority_work_stealing_scheduler
  import pwss_pkg::*;
#(
  parameter int WORKERS     = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[1:0], task_id[17:2], priority_req[25:18], worker_index[28:26], zero fill
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], started[3], start_worker[6:4], start_task[22:7], queued[23],
  // stolen[24], pool_idle[25], zero fill
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int WB   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int QB   = $clog2(QUEUE_DEPTH);
  localparam int LB   = $clog2(QUEUE_DEPTH + 1);
  localparam int MD   = WORKERS * QUEUE_DEPTH;
  localparam int AB   = (MD > 1) ? $clog2(MD) : 1;
  localparam int EW   = TASK_BITS + PRIO_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_INS_RD, S_INS_CMP, S_INS_DONE,
    S_SCAN, S_POP_RD, S_POP_SH, S_POP_DONE, S_OUT
  } state_t;

  state_t state;

  logic [3:0]             worker_count;
  logic                   pool_stopped;
  logic [LB-1:0]          qlen [WORKERS];
  logic [WORKERS-1:0]     busy;
  logic [TASK_BITS-1:0]   active [WORKERS];

  logic [OP_BITS-1:0]     op;
  logic [15:0]            task_in;
  logic [PRIO_BITS-1:0]   prio_in;
  logic [2:0]             widx;
  logic [3:0]             n_use;

  logic [WB-1:0]          tw;       // target worker
  logic [WB-1:0]          scan;
  logic [LB-1:0]          pos;
  logic                   do_pop;   // insert then pop on an idle worker
  logic                   is_steal;
  logic [WB-1:0]          src;

  logic [STATUS_BITS-1:0] r_status;
  logic                   r_started, r_queued, r_stolen;
  logic [2:0]             r_worker;
  logic [15:0]            r_task;

  logic                   wr_en;
  logic [AB-1:0]          wr_addr, rd_addr;
  logic [EW-1:0]          wr_data, rd_data;
  logic [TASK_BITS-1:0]   front_task;

  pwss_queue_mem #(.DEPTH(MD), .WIDTH(EW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  function automatic logic [AB-1:0] addr_of(input logic [WB-1:0] w, input logic [LB-1:0] p);
    logic [AB+LB-1:0] a;
    a = (AB+LB)'(w) * (AB+LB)'(QUEUE_DEPTH) + (AB+LB)'(p);
    return a[AB-1:0];
  endfunction

  assign s_tready  = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (worker_count == 4'd0) n_use = 4'd1;
    else if (worker_count > 4'(WORKERS)) n_use = 4'(WORKERS);
    else n_use = worker_count;
  end

  // Lowest idle worker in use.
  logic [WB-1:0] idle_w;
  logic          idle_found;
  always_comb begin
    idle_w = '0;
    idle_found = 1'b0;
    for (int w = WORKERS - 1; w >= 0; w--) begin
      if (w < n_use && !busy[w]) begin
        idle_w = WB'(w);
        idle_found = 1'b1;
      end
    end
  end

  logic pool_idle;
  always_comb begin
    pool_idle = (busy == '0);
    for (int w = 0; w < WORKERS; w++) begin
      if (qlen[w] != '0) pool_idle = 1'b0;
    end
  end

  // Memory port steering.
  logic [LB-1:0] len_t, len_s;
  assign len_t = qlen[tw];
  assign len_s = qlen[src];
  logic signed [PRIO_BITS-1:0] cmp_p;
  assign cmp_p = rd_data[EW-1:TASK_BITS];
  assign front_task = rd_data[TASK_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_of(tw, pos);
    wr_data = {prio_in, TASK_BITS'(task_in)};
    rd_addr = addr_of(tw, pos - LB'(1));
    unique case (state)
      S_INS_CMP: begin
        wr_en = 1'b1;
        if ($signed(prio_in) > cmp_p) wr_data = rd_data;
      end
      S_INS_DONE: wr_en = 1'b1;
      S_POP_RD:   rd_addr = addr_of(src, pos);
      S_POP_SH: begin
        // rd_data holds entry pos-1; it moves to pos-2
        wr_en   = (pos >= LB'(2));
        wr_addr = addr_of(src, pos - LB'(2));
        wr_data = rd_data;
        rd_addr = addr_of(src, pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      worker_count <= 4'd4;
      pool_stopped <= 1'b0;
      busy         <= '0;
      m_tvalid     <= 1'b0;
      for (int w = 0; w < WORKERS; w++) qlen[w] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WORKER_COUNT: worker_count <= cfg_data;
          CFG_POOL_STOPPED: pool_stopped <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op        <= s_tdata[1:0];
          task_in   <= s_tdata[17:2];
          prio_in   <= s_tdata[25:18];
          widx      <= s_tdata[28:26];
          r_status  <= ST_OK;
          r_started <= 1'b0;
          r_queued  <= 1'b0;
          r_stolen  <= 1'b0;
          r_worker  <= '0;
          r_task    <= '0;
          state     <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_OUT;
          if (op == OP_SUBMIT || op == OP_TRY) begin
            if (pool_stopped) r_status <= ST_STOPPED;
            else if (!idle_found) begin
              if (op == OP_TRY) r_status <= ST_NO_IDLE;
              else if (qlen[0] >= LB'(QUEUE_DEPTH)) r_status <= ST_FULL;
              else begin
                tw <= '0; pos <= qlen[0]; do_pop <= 1'b0; state <= S_INS_RD;
              end
            end else if (qlen[idle_w] >= LB'(QUEUE_DEPTH)) r_status <= ST_FULL;
            else if (qlen[idle_w] == '0) begin
              busy[idle_w]   <= 1'b1;
              active[idle_w] <= TASK_BITS'(task_in);
              r_started <= 1'b1;
              r_worker  <= 3'(idle_w);
              r_task    <= 16'(TASK_BITS'(task_in));
            end else begin
              tw <= idle_w; pos <= qlen[idle_w]; do_pop <= 1'b1; state <= S_INS_RD;
            end
          end else if (op == OP_COMPLETE) begin
            if ({1'b0, widx} >= n_use || !busy[WB'(widx)]) r_status <= ST_NO_TASK;
            else begin
              tw <= WB'(widx);
              busy[WB'(widx)] <= 1'b0;
              if (qlen[WB'(widx)] != '0) begin
                src <= WB'(widx); is_steal <= 1'b0; pos <= '0; state <= S_POP_RD;
              end else begin
                scan <= '0; state <= S_SCAN;
              end
            end
          end
        end
        S_INS_RD: state <= (pos == '0) ? S_INS_DONE : S_INS_CMP;
        S_INS_CMP: begin
          if ($signed(prio_in) > cmp_p) begin
            pos   <= pos - LB'(1);
            state <= S_INS_RD;
          end else begin
            qlen[tw] <= len_t + LB'(1);
            r_queued <= !do_pop;
            state    <= do_pop ? S_POP_RD : S_OUT;
            src <= tw; is_steal <= 1'b0; pos <= '0;
          end
        end
        S_INS_DONE: begin
          qlen[tw] <= len_t + LB'(1);
          r_queued <= !do_pop;
          state    <= do_pop ? S_POP_RD : S_OUT;
          src <= tw; is_steal <= 1'b0; pos <= '0;
        end
        S_SCAN: begin
          if (scan != tw && qlen[scan] != '0) begin
            src <= scan; is_steal <= 1'b1; pos <= '0; state <= S_POP_RD;
          end else if (4'(scan) + 4'd1 >= n_use || scan == WB'(WORKERS - 1)) begin
            state <= S_OUT;
          end else scan <= scan + WB'(1);
        end
        S_POP_RD: begin
          pos   <= pos + LB'(1);
          state <= S_POP_SH;
        end
        S_POP_SH: begin
          if (pos == LB'(1)) begin
            busy[tw]   <= 1'b1;
            active[tw] <= front_task;
            r_started  <= 1'b1;
            r_worker   <= 3'(tw);
            r_task     <= 16'(front_task);
            r_stolen   <= is_steal;
          end
          if (pos >= len_s) state <= S_POP_DONE;
          else pos <= pos + LB'(1);
        end
        S_POP_DONE: begin
          qlen[src] <= len_s - LB'(1);
          state     <= S_OUT;
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, pool_idle, r_stolen, r_queued, r_task, r_worker, r_started, r_status};

`ifndef SYNTH
  a_started_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && r_started) |=> busy[WB'(r_worker)])
    else $error("started worker not busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("ready while working");
  a_qlen_range: assert property (@(posedge clk) disable iff (rst)
    qlen[0] <= LB'(QUEUE_DEPTH))
    else $error("queue overflow");
  a_queued_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !(r_queued && r_started))
    else $error("queued and started together");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for priority_work_stealing_scheduler: directed table, then random traffic.
// Uses pwss_pkg for opcodes, status codes and register indexes; predicts every result in-bench.
`timescale 1ns / 1ps

module tb;
  import pwss_pkg::*;

  localparam int NW = 4;
  localparam int QD = 16;
  localparam int EXP_MAX = 2048;

  // lowest bit last: matches the m_tdata layout from bit 0 up
  typedef struct packed {
    logic        idle;
    logic        stolen;
    logic        queued;
    logic [15:0] stask;
    logic [2:0]  sworker;
    logic        started;
    logic [2:0]  status;
  } sched_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] tid;
    logic [7:0]  prio;
    logic [2:0]  widx;
    logic        has_exp;
    sched_res_t  exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [3:0] cfg_data = '0;

  priority_work_stealing_scheduler u_dut (.*);

  // predictor state
  logic [15:0] qtask [NW][QD];
  logic signed [7:0] qprio [NW][QD];
  int qlen [NW];
  logic busy [NW];
  logic [3:0] wcount;
  logic stopped;

  sched_res_t exp_list [EXP_MAX];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int n_started = 0;
  int n_stolen = 0;
  int n_full = 0;
  bit no_idle_gaps = 0;
  bit hold_rx = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("timeout");
    $display("priority_work_stealing_scheduler regression: fail");
    $finish;
  end

  function automatic void q_insert(int w, logic [15:0] t, logic signed [7:0] p);
    int pos;
    pos = 0;
    while (pos < qlen[w] && p <= qprio[w][pos]) pos++;
    for (int i = qlen[w]; i > pos; i--) begin
      qtask[w][i] = qtask[w][i-1];
      qprio[w][i] = qprio[w][i-1];
    end
    qtask[w][pos] = t;
    qprio[w][pos] = p;
    qlen[w]++;
  endfunction

  function automatic logic [15:0] q_pop(int w);
    logic [15:0] t;
    t = qtask[w][0];
    for (int i = 1; i < qlen[w]; i++) begin
      qtask[w][i-1] = qtask[w][i];
      qprio[w][i-1] = qprio[w][i];
    end
    qlen[w]--;
    return t;
  endfunction

  function automatic sched_res_t dispatch(logic [1:0] op, logic [15:0] tid,
                                          logic [7:0] prio, logic [2:0] widx);
    sched_res_t r;
    int n, idle, src;
    r = '0;
    n = (wcount < 1) ? 1 : (wcount > NW) ? NW : wcount;
    if (op == OP_SUBMIT || op == OP_TRY) begin
      idle = n;
      for (int w = n - 1; w >= 0; w--) if (!busy[w]) idle = w;
      if (stopped) r.status = ST_STOPPED;
      else if (idle == n) begin
        if (op == OP_TRY) r.status = ST_NO_IDLE;
        else if (qlen[0] >= QD) r.status = ST_FULL;
        else begin
          q_insert(0, tid, prio);
          r.queued = 1'b1;
        end
      end else if (qlen[idle] >= QD) r.status = ST_FULL;
      else begin
        q_insert(idle, tid, prio);
        r.stask = q_pop(idle);
        busy[idle] = 1'b1;
        r.started = 1'b1;
        r.sworker = idle;
      end
    end else if (op == OP_COMPLETE) begin
      if (widx >= n || !busy[widx]) r.status = ST_NO_TASK;
      else begin
        busy[widx] = 1'b0;
        src = widx;
        if (qlen[widx] == 0) begin
          src = n;
          for (int w = n - 1; w >= 0; w--) if (w != widx && qlen[w] != 0) src = w;
        end
        if (src < n) begin
          r.stask = q_pop(src);
          busy[widx] = 1'b1;
          r.started = 1'b1;
          r.sworker = widx;
          r.stolen = (src != widx);
        end
      end
    end
    r.idle = 1'b1;
    for (int w = 0; w < NW; w++) if (busy[w] || qlen[w] != 0) r.idle = 1'b0;
    return r;
  endfunction

  task automatic gap();
    if (!no_idle_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [15:0] tid, logic [7:0] prio,
                           logic [2:0] widx, bit has_exp, sched_res_t exp);
    sched_res_t r;
    gap();
    s_tdata <= {3'b0, widx, prio, tid, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r = dispatch(op, tid, prio, widx);
    if (has_exp && r != exp)
      $display("%0t table row disagrees with predictor: table %h predictor %h", $time, exp, r);
    exp_list[exp_wr] = has_exp ? exp : r;
    exp_wr++;
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WORKER_COUNT) wcount = val;
    else stopped = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side
  always @(posedge clk) begin
    sched_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[25:0];
      n_results++;
      if (got.started) n_started++;
      if (got.stolen) n_stolen++;
      if (got.status == ST_FULL) n_full++;
      if (exp_rd == exp_wr) begin
        $display("%0t unexpected item: actual %h", $time, got);
        errors++;
      end else begin
        want = exp_list[exp_rd];
        exp_rd++;
        if (got != want || m_tdata[31:26] != 0) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, m_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_rx) m_tready <= 1'b0;
      else if (!no_idle_gaps && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall - 1) @(negedge clk);
      end else m_tready <= 1'b1;
    end
  end

  function automatic sched_res_t mk(logic [2:0] st, logic s, logic [2:0] w,
                                    logic [15:0] t, logic q, logic sl, logic i);
    return '{status: st, started: s, sworker: w, stask: t, queued: q, stolen: sl, idle: i};
  endfunction

  initial begin
    dir_row_t rows [17];
    sched_res_t nil;
    logic [1:0] op;
    int k;
    nil = '0;
    for (int w = 0; w < NW; w++) begin
      qlen[w] = 0;
      busy[w] = 1'b0;
    end
    wcount = 4'd4;
    stopped = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    rows[0]  = '{OP_COMPLETE, 16'h0, 8'h0, 3'd0, 1, mk(ST_NO_TASK, 0, 0, 0, 0, 0, 1)};
    rows[1]  = '{2'd3, 16'hffff, 8'h80, 3'd7, 1, mk(ST_OK, 0, 0, 0, 0, 0, 1)};
    rows[2]  = '{OP_SUBMIT, 16'hffff, 8'h7f, 3'd7, 1, mk(ST_OK, 1, 0, 16'hffff, 0, 0, 0)};
    rows[3]  = '{OP_TRY, 16'h0000, 8'h80, 3'd0, 1, mk(ST_OK, 1, 1, 16'h0, 0, 0, 0)};
    rows[4]  = '{OP_SUBMIT, 16'h1234, 8'h00, 3'd0, 0, nil};
    rows[5]  = '{OP_SUBMIT, 16'h5678, 8'h01, 3'd0, 0, nil};
    rows[6]  = '{OP_TRY, 16'h1111, 8'h00, 3'd0, 1, mk(ST_NO_IDLE, 0, 0, 0, 0, 0, 0)};
    rows[7]  = '{OP_SUBMIT, 16'ha001, 8'h05, 3'd0, 0, nil};
    rows[8]  = '{OP_SUBMIT, 16'ha002, 8'h7f, 3'd0, 0, nil};
    rows[9]  = '{OP_SUBMIT, 16'ha003, 8'h05, 3'd0, 0, nil};
    rows[10] = '{OP_SUBMIT, 16'ha004, 8'h80, 3'd0, 0, nil};
    rows[11] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd7, 1, mk(ST_NO_TASK, 0, 0, 0, 0, 0, 0)};
    rows[12] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd2, 0, nil};
    rows[13] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd0, 0, nil};
    rows[14] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd1, 0, nil};
    rows[15] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd3, 0, nil};
    rows[16] = '{OP_COMPLETE, 16'h0, 8'h0, 3'd3, 0, nil};
    foreach (rows[i])
      send_item(rows[i].op, rows[i].tid, rows[i].prio, rows[i].widx, rows[i].has_exp,
                rows[i].exp);

    write_reg(CFG_POOL_STOPPED, 4'd1);
    send_item(OP_SUBMIT, 16'h4444, 8'h10, 3'd0, 1, mk(ST_STOPPED, 0, 0, 0, 0, 0, 0));
    send_item(OP_TRY, 16'h4445, 8'h10, 3'd0, 1, mk(ST_STOPPED, 0, 0, 0, 0, 0, 0));
    send_item(OP_COMPLETE, 16'h0, 8'h0, 3'd0, 0, nil);
    write_reg(CFG_POOL_STOPPED, 4'd0);

    // long receiver hold while the sender keeps offering items
    fork
      begin
        hold_rx = 1;
        repeat (400) @(negedge clk);
        hold_rx = 0;
      end
      begin
        for (int i = 0; i < 12; i++) send_item(OP_SUBMIT, $urandom, $urandom, 0, 0, nil);
        s_tvalid <= 1'b0;
      end
    join

    k = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(CFG_WORKER_COUNT, 4'd1);
        1: write_reg(CFG_WORKER_COUNT, 4'd0);
        2: write_reg(CFG_WORKER_COUNT, 4'd15);
        3: write_reg(CFG_WORKER_COUNT, 4'd2);
        4: write_reg(CFG_WORKER_COUNT, 4'd3);
        default: write_reg(CFG_WORKER_COUNT, 4'd4);
      endcase
      if (phase == 5) no_idle_gaps = 1;
      for (int i = 0; i < 185; i++) begin
        k = $urandom_range(0, 99);
        op = (k < 45) ? OP_SUBMIT : (k < 55) ? OP_TRY : (k < 97) ? OP_COMPLETE : 2'd3;
        // for even k only priorities 0 to 3, so ties are common
        send_item(op, $urandom, (k & 1) ? $urandom : 8'($urandom_range(0, 3)),
                  (k < 90) ? 3'($urandom_range(0, 3)) : 3'($urandom), 0, nil);
      end
    end

    no_idle_gaps = 1;
    drain();
    $display("sent %0d items, checked %0d results: %0d starts, %0d steals, %0d queue-full",
             n_sent, n_results, n_started, n_stolen, n_full);
    if (errors == 0 && exp_rd == exp_wr)
      $display("priority_work_stealing_scheduler regression: pass");
    else
      $display("priority_work_stealing_scheduler regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pwss_pkg.sv
rtl/core/pwss_queue_mem.sv
rtl/core/priority_work_stealing_scheduler.sv
bench/tb.sv
